// File: hdl/brec_pkg.sv
// shared constants and types for the bit row equivalence classifier
// no dependencies; imported by every module of the block but brec_ram

package brec_pkg;

	localparam int ROW_BITS    = 64;
	localparam int TABLE_DEPTH = 128;

	// fixed widths of the port fields
	localparam int TAG_W    = 16;
	localparam int ROW_IN_W = 64;
	localparam int UCNT_W   = 8;

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	typedef struct packed {
		logic [TAG_W-1:0]    tag;
		logic [ROW_BITS-1:0] row;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// table access from the scan controller
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;

	// finished classification handed to the output register
	typedef struct packed {
		logic              valid;
		logic [TAG_W-1:0]  class_tag;
		logic              is_new;
		logic              table_full;
		logic [UCNT_W-1:0] unique_count;
	} result_t;

endpackage

// File: hdl/brec_ram.sv
// generic single-clock ram: one write port, one read port, registered read
// no dependencies

module brec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/brec_scan.sv
// scan controller: walks the table in insertion order, appends new rows
// depends on brec_pkg; drives the entry ram through mem_req_t

module brec_scan import brec_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [TAG_W-1:0]    start_tag,
	input  logic [ROW_BITS-1:0] start_row,
	output logic                busy,
	output mem_req_t            mem_req,
	input  entry_t              rd_data,
	output result_t             res,
	input  logic                res_ready
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    issue_q;
	logic                cmp_v_q;
	logic [TAG_W-1:0]    tag_q;
	logic [ROW_BITS-1:0] row_q;
	logic [TAG_W-1:0]    res_tag_q;
	logic                res_new_q;
	logic                res_full_q;

	logic                   hit;
	logic                   miss_done;
	logic                   room;
	logic                   rd_en;
	logic [CNT_W+UCNT_W-1:0] count_ext;

	assign hit       = cmp_v_q && (rd_data.row == row_q);
	assign miss_done = !hit && (issue_q == count_q);
	assign room      = count_q < CNT_W'(TABLE_DEPTH);
	assign rd_en     = (state_q == ST_SCAN) && (issue_q != count_q) && !hit;

	always_comb begin
		mem_req.rd_en        = rd_en;
		mem_req.rd_addr      = issue_q[ADDR_W-1:0];
		mem_req.wr_en        = (state_q == ST_SCAN) && miss_done && room;
		mem_req.wr_addr      = count_q[ADDR_W-1:0];
		mem_req.wr_data.tag  = tag_q;
		mem_req.wr_data.row  = row_q;
	end

	// saturate the count to the 8-bit field
	assign count_ext = {{UCNT_W{1'b0}}, count_q};

	always_comb begin
		res.valid        = (state_q == ST_HOLD);
		res.class_tag    = res_tag_q;
		res.is_new       = res_new_q;
		res.table_full   = res_full_q;
		res.unique_count = (count_ext > (CNT_W+UCNT_W)'(255)) ? 8'hFF : count_ext[UCNT_W-1:0];
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			issue_q <= '0;
			cmp_v_q <= 1'b0;
		end else begin
			cmp_v_q <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						issue_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (hit) begin
						state_q <= ST_HOLD;
					end else if (miss_done) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			tag_q <= start_tag;
			row_q <= start_row;
		end
		if (state_q == ST_SCAN) begin
			if (hit) begin
				res_tag_q  <= rd_data.tag;
				res_new_q  <= 1'b0;
				res_full_q <= 1'b0;
			end else if (miss_done) begin
				res_tag_q  <= tag_q;
				res_new_q  <= 1'b1;
				res_full_q <= !room;
			end
		end
	end

endmodule

// File: hdl/bit_row_equivalence_classifier.sv
// top level: deduplicating table of bit rows with first-match class tags
// depends on brec_pkg, brec_ram (entry table) and brec_scan (scan control)
// the scan reads the entries in order up to the first match, or every stored row
//   for a new row, and the result then passes through the output register
// throughput: one item at a time, the next input transfer only after the scan has
//   handed its result on; one table entry compared per cycle through the
//   single read port of the entry ram; the scan stops at the first match
// reset: arst_n clears the entry count and all handshake state; table contents
//   are not cleared, entries at and above the count are never read

module bit_row_equivalence_classifier import brec_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [TAG_W-1:0]    row_tag,
	input  logic [ROW_IN_W-1:0] row_bits,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [TAG_W-1:0]    class_tag,
	output logic                is_new,
	output logic                table_full,
	output logic [UCNT_W-1:0]   unique_count
);

	mem_req_t mem_req;
	entry_t   rd_data;
	result_t  res;
	logic     busy;
	logic     start;
	logic     res_ready;
	logic     out_valid_q;

	// the scan takes a new item only while idle
	assign in_stall = busy;
	assign start    = in_valid && !busy;

	// output register can load when empty or when its content is taken now
	assign res_ready = !out_valid_q || !out_stall;

	// entry table: tag and row of each stored unique row, insertion order
	brec_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_req.wr_en),
		.waddr (mem_req.wr_addr),
		.wdata (mem_req.wr_data),
		.re    (mem_req.rd_en),
		.raddr (mem_req.rd_addr),
		.rdata (rd_data)
	);

	// scan controller, only the low ROW_BITS columns take part in the compare
	brec_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_tag (row_tag),
		.start_row (row_bits[ROW_BITS-1:0]),
		.busy      (busy),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register: valid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	// output register: payload, held while the transfer is stalled
	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			class_tag    <= res.class_tag;
			is_new       <= res.is_new;
			table_full   <= res.table_full;
			unique_count <= res.unique_count;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: dv/bit_row_equivalence_classifier_tb.sv
// self-checking testbench for bit_row_equivalence_classifier
// depends on brec_pkg and the block's rtl; keeps its own copy of the row table
// to predict class tags, new and full flags and the unique count of every transfer

module bit_row_equivalence_classifier_tb;
	import brec_pkg::*;

	localparam int LONG_HOLD = 300;        // receiver hold-off in cycles
	localparam int TIMEOUT   = 10_000_000; // time limit for the hang guard

	// only the low ROW_BITS bits of a row take part in the comparison
	localparam logic [ROW_IN_W-1:0] ROW_MASK = {ROW_IN_W{1'b1}} >> (ROW_IN_W - ROW_BITS);

	// what the block should report for one row
	typedef struct {
		logic [TAG_W-1:0]  class_tag;
		logic              is_new;
		logic              table_full;
		logic [UCNT_W-1:0] unique_count;
	} row_verdict_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [TAG_W-1:0]    row_tag;
	logic [ROW_IN_W-1:0] row_bits;
	logic                out_valid;
	logic                out_stall;
	logic [TAG_W-1:0]    class_tag;
	logic                is_new;
	logic                table_full;
	logic [UCNT_W-1:0]   unique_count;

	// shadow table: unique rows in insertion order and the tag each was stored with
	logic [ROW_BITS-1:0] seen_rows [TABLE_DEPTH];
	logic [TAG_W-1:0]    seen_tags [TABLE_DEPTH];
	int                  seen_count = 0;

	row_verdict_t pending_verdicts[$];
	int           fail_cnt = 0;

	// idling controls for the sender and the receiver
	bit src_idle_en   = 1'b1;
	bit sink_idle_en  = 1'b1;
	bit long_hold_req = 1'b0;

	bit_row_equivalence_classifier DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row_tag      (row_tag),
		.row_bits     (row_bits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.class_tag    (class_tag),
		.is_new       (is_new),
		.table_full   (table_full),
		.unique_count (unique_count)
	);

	always #5 clk = ~clk;

	// first-match search over the shadow table; appends the row when it is new
	// and there is still room, exactly as the block should
	function automatic row_verdict_t classify_row(input logic [TAG_W-1:0] tag,
			input logic [ROW_IN_W-1:0] bits);
		row_verdict_t        v;
		logic [ROW_BITS-1:0] key;
		int                  hit;
		key = bits[ROW_BITS-1:0];
		hit = -1;
		for (int i = 0; i < seen_count; i++)
			if (hit < 0 && seen_rows[i] == key)
				hit = i;
		v.class_tag  = tag;
		v.is_new     = 1'b1;
		v.table_full = 1'b0;
		if (hit >= 0) begin
			v.class_tag = seen_tags[hit];
			v.is_new    = 1'b0;
		end else if (seen_count < TABLE_DEPTH) begin
			seen_rows[seen_count] = key;
			seen_tags[seen_count] = tag;
			seen_count++;
		end else begin
			v.table_full = 1'b1;
		end
		// the reported count saturates when the table is deeper than the field
		v.unique_count = (seen_count > (1 << UCNT_W) - 1) ? {UCNT_W{1'b1}}
			: UCNT_W'(seen_count);
		return v;
	endfunction

	// offer one row and hold it until the block takes it; an optional idle
	// burst goes in front; returns at the accepting rising edge
	task automatic send_row(input logic [TAG_W-1:0] tag, input logic [ROW_IN_W-1:0] bits);
		@(negedge clk);
		if (src_idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		row_tag  <= tag;
		row_bits <= bits;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_verdicts.insert(pending_verdicts.size(), classify_row(tag, bits));
	endtask

	// drop valid after the last transfer so the same row is not taken twice
	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// sender pause until every pending result has come out
	task automatic wait_results();
		idle_input();
		wait (pending_verdicts.size() == 0);
	endtask

	// random tag with the extremes showing up now and then
	function automatic logic [TAG_W-1:0] pick_tag();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return TAG_W'($urandom);
		endcase
	endfunction

	// extremes of both fields, first-match on repeated rows and reused tags;
	// the row is as wide as the input, so no bits lie above the row width
	task automatic test_directed();
		send_row(16'h0000, 64'h0);
		send_row(16'hFFFF, {ROW_IN_W{1'b1}});
		send_row(16'h0001, 64'h0);
		send_row(16'h0000, {ROW_IN_W{1'b1}});
		send_row(16'h0002, 64'h1);
		send_row(16'h0003, ROW_IN_W'(1) << (ROW_BITS - 1));
		send_row(16'h8000, 64'hAAAA_AAAA_AAAA_AAAA);
		send_row(16'h7FFF, 64'h5555_5555_5555_5555);
		send_row(16'h0004, 64'h1);
		// same tag, different row: two entries carry tag 2
		send_row(16'h0002, 64'h2);
		send_row(16'h0005, 64'h2);
		send_row(16'h0006, 64'hAAAA_AAAA_AAAA_AAAA);
		send_row(16'hFFFF, 64'h0);
		// no bits lie above the row width, so this is the all-zero row again
		send_row(16'h1234, ~ROW_MASK);
		send_row(16'h4321, ROW_MASK);
	endtask

	// receiver holds off for a long stretch while rows keep coming, so the
	// block fills up and stalls its input
	task automatic test_backpressure();
		long_hold_req = 1'b1;
		repeat (10)
			send_row(pick_tag(), {$urandom, $urandom});
	endtask

	// repeats of stored rows at every depth for half the items, fresh rows and one-bit
	// near misses; the last entry gets extra weight for the longest scan
	task automatic run_random_mix(input int n_items);
		logic [ROW_IN_W-1:0] bits;
		int                  kind;
		int                  idx;
		for (int k = 0; k < n_items; k++) begin
			bits = {$urandom, $urandom};
			kind = (seen_count == 0) ? 0 : $urandom_range(0, 9);
			if (kind >= 5) begin
				idx = ($urandom_range(0, 3) == 0) ? seen_count - 1
					: $urandom_range(0, seen_count - 1);
				bits[ROW_BITS-1:0] = seen_rows[idx];
			end else if (kind == 4) begin
				idx = $urandom_range(0, seen_count - 1);
				bits[ROW_BITS-1:0] = seen_rows[idx];
				idx = $urandom_range(0, ROW_BITS - 1);
				bits[idx] = ~bits[idx];
			end
			send_row(pick_tag(), bits);
		end
	endtask

	// sender goes quiet until the block has drained, then resumes
	task automatic test_drain_pause();
		run_random_mix(20);
		wait_results();
		repeat ($urandom_range(1, 17)) @(negedge clk);
		run_random_mix(20);
	endtask

	// top the table up, then a new row that finds no room and hits on the
	// first and the last entry of a full table
	task automatic test_table_full();
		int tries;
		tries = 0;
		while (seen_count < TABLE_DEPTH && tries < 4 * TABLE_DEPTH) begin
			send_row(pick_tag(), {$urandom, $urandom});
			tries++;
		end
		send_row(16'hBEEF, {$urandom, $urandom});
		send_row(16'h0000, ROW_IN_W'(seen_rows[0]));
		send_row(16'hFFFF, ROW_IN_W'(seen_rows[seen_count-1]));
		send_row(16'h0000, {$urandom, $urandom});
	endtask

	// receiver: random stall bursts, or one long hold-off when asked for;
	// exactly one assignment to out_stall per falling edge
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (long_hold_req) begin
					stall_left    = LONG_HOLD;
					long_hold_req = 1'b0;
				end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 17);
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// compare every result transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		row_verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("result transfer with no row pending: class_tag %h", class_tag);
				fail_cnt++;
			end else begin
				want = pending_verdicts.pop_front();
				if (class_tag !== want.class_tag) begin
					$error("class_tag mismatch: expected %h, actual %h",
						want.class_tag, class_tag);
					fail_cnt++;
				end
				if (is_new !== want.is_new) begin
					$error("is_new mismatch: expected %b, actual %b", want.is_new, is_new);
					fail_cnt++;
				end
				if (table_full !== want.table_full) begin
					$error("table_full mismatch: expected %b, actual %b",
						want.table_full, table_full);
					fail_cnt++;
				end
				if (unique_count !== want.unique_count) begin
					$error("unique_count mismatch: expected %0d, actual %0d",
						want.unique_count, unique_count);
					fail_cnt++;
				end
			end
		end
	end

	// sequence of tests; reset once at the start
	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		row_tag  = '0;
		row_bits = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_backpressure();
		test_drain_pause();
		run_random_mix(400);
		test_table_full();
		run_random_mix(480);

		// closing stretch at full rate on both sides
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		run_random_mix(150);
		idle_input();

		// drain, then allow a full scan for any stray result
		wait (pending_verdicts.size() == 0);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// hang guard
	initial begin
		#TIMEOUT;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
hdl/brec_pkg.sv
hdl/brec_ram.sv
hdl/brec_scan.sv
hdl/bit_row_equivalence_classifier.sv
dv/bit_row_equivalence_classifier_tb.sv
